FILE: hw/rtl/rvx_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types for the rv32i subset execute block
// no dependencies

package rvx_pkg;

	localparam int unsigned DATA_BYTES_DEF = 4096;

	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
	localparam logic [6:0] OPC_OP     = 7'b0110011;

	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_W    = 3'd2;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SRL  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_B    = 3'd0;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [1:0] FAULT_NONE     = 2'd0;
	localparam logic [1:0] FAULT_ILLEGAL  = 2'd1;
	localparam logic [1:0] FAULT_MISALIGN = 2'd2;

	localparam logic [31:0] JALR_MASK = 32'hFFFF_FFFE;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EX,
		ST_MEM
	} state_t;

	typedef struct packed {
		logic [31:0] npc;
		logic        taken;
		logic        wr;
		logic [4:0]  rd;
		logic [31:0] val;
		logic        load_b;
		logic        load_w;
		logic        store;
		logic [3:0]  be;
		logic [31:0] wdata;
		logic [31:0] addr;
		logic [1:0]  fault;
	} exec_t;

endpackage

FILE: hw/rtl/rvx_regfile.sv
`timescale 1ns / 1ps
// 32 x 32 register file in synchronous ram, two read ports, one write port
// depends on rvx_pkg

module rvx_regfile
	import rvx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        re,
	input  logic [4:0]  ra,
	input  logic [4:0]  rb,
	output logic [31:0] rdata_a,
	output logic [31:0] rdata_b,
	input  logic        we,
	input  logic [4:0]  wa,
	input  logic [31:0] wd
);

	logic [31:0] mem_q [32];
	logic [31:0] ra_data_q;
	logic [31:0] rb_data_q;
	logic [31:0] valid_q;
	logic        va_q;
	logic        vb_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (re) begin
			ra_data_q <= mem_q[ra];
			rb_data_q <= mem_q[rb];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			if (we) begin
				valid_q[wa] <= 1'b1;
			end
			if (re) begin
				va_q <= valid_q[ra];
				vb_q <= valid_q[rb];
			end
		end
	end

	assign rdata_a = va_q ? ra_data_q : '0;
	assign rdata_b = vb_q ? rb_data_q : '0;

endmodule

FILE: hw/rtl/rvx_dmem.sv
`timescale 1ns / 1ps
// word-wide data memory with byte enables and a clearing sweep after reset
// depends on rvx_pkg

module rvx_dmem
	import rvx_pkg::*;
#(
	parameter int unsigned DATA_BYTES = DATA_BYTES_DEF,
	localparam int unsigned WORDS = DATA_BYTES / 4,
	localparam int unsigned AW = $clog2(WORDS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          we,
	input  logic [3:0]    be,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata,
	output logic          busy
);

	logic [31:0]   mem_q [WORDS];
	logic [31:0]   rdata_q;
	logic [AW-1:0] clr_addr_q;
	logic          busy_q;
	logic          wr_act;
	logic [3:0]    wr_be;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(WORDS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (busy_q) begin
			wr_act  = 1'b1;
			wr_be   = 4'b1111;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_act  = en & we;
			wr_be   = be;
			wr_addr = addr;
			wr_data = wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_act) begin
			for (int i = 0; i < 4; i++) begin
				if (wr_be[i]) begin
					mem_q[wr_addr][i*8 +: 8] <= wr_data[i*8 +: 8];
				end
			end
		end
		if (en && !we && !busy_q) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

FILE: hw/rtl/rvx_exec.sv
`timescale 1ns / 1ps
// instruction decode, alu, branch and address generation
// depends on rvx_pkg

module rvx_exec
	import rvx_pkg::*;
(
	input  logic [31:0] instr,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] pc,
	output exec_t       ex
);

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rd;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] imm_u;
	logic [31:0] pc4;
	logic        cond;

	always_comb begin
		opc   = instr[6:0];
		rd    = instr[11:7];
		f3    = instr[14:12];
		f7    = instr[31:25];
		imm_i = {{20{instr[31]}}, instr[31:20]};
		imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
		imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
		imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
		imm_u = {instr[31:12], 12'b0};
		pc4   = pc + 32'd4;
		cond  = 1'b0;

		ex        = '0;
		ex.npc    = pc4;
		ex.rd     = rd;
		ex.fault  = FAULT_NONE;
		ex.addr   = a + imm_i;

		unique case (opc)
			OPC_LUI: begin
				ex.wr  = 1'b1;
				ex.val = imm_u;
			end
			OPC_AUIPC: begin
				ex.wr  = 1'b1;
				ex.val = pc + imm_u;
			end
			OPC_JAL: begin
				ex.wr    = 1'b1;
				ex.val   = pc4;
				ex.npc   = pc + imm_j;
				ex.taken = 1'b1;
			end
			OPC_JALR: begin
				if (f3 != F3_ADD) begin
					ex.fault = FAULT_ILLEGAL;
				end else begin
					ex.wr    = 1'b1;
					ex.val   = pc4;
					ex.npc   = (a + imm_i) & JALR_MASK;
					ex.taken = 1'b1;
				end
			end
			OPC_BRANCH: begin
				unique case (f3)
					F3_BEQ:  cond = (a == b);
					F3_BNE:  cond = (a != b);
					F3_BLT:  cond = ($signed(a) < $signed(b));
					F3_BGE:  cond = ($signed(a) >= $signed(b));
					F3_BLTU: cond = (a < b);
					F3_BGEU: cond = (a >= b);
					default: ex.fault = FAULT_ILLEGAL;
				endcase
				ex.taken = cond;
				if (cond) begin
					ex.npc = pc + imm_b;
				end
			end
			OPC_LOAD: begin
				if (f3 == F3_B) begin
					ex.wr     = 1'b1;
					ex.load_b = 1'b1;
				end else if (f3 == F3_W) begin
					if (ex.addr[1:0] != 2'b00) begin
						ex.fault = FAULT_MISALIGN;
					end else begin
						ex.wr     = 1'b1;
						ex.load_w = 1'b1;
					end
				end else begin
					ex.fault = FAULT_ILLEGAL;
				end
			end
			OPC_STORE: begin
				ex.addr = a + imm_s;
				if (f3 == F3_B) begin
					ex.store = 1'b1;
					ex.be    = 4'b0001 << ex.addr[1:0];
					ex.wdata = {4{b[7:0]}};
				end else if (f3 == F3_W) begin
					if (ex.addr[1:0] != 2'b00) begin
						ex.fault = FAULT_MISALIGN;
					end else begin
						ex.store = 1'b1;
						ex.be    = 4'b1111;
						ex.wdata = b;
					end
				end else begin
					ex.fault = FAULT_ILLEGAL;
				end
			end
			OPC_OPIMM: begin
				ex.wr = 1'b1;
				unique case (f3)
					F3_ADD:  ex.val = a + imm_i;
					F3_XOR:  ex.val = a ^ imm_i;
					F3_OR:   ex.val = a | imm_i;
					F3_AND:  ex.val = a & imm_i;
					default: ex.fault = FAULT_ILLEGAL;
				endcase
			end
			OPC_OP: begin
				ex.wr = 1'b1;
				if (f7 == F7_BASE) begin
					unique case (f3)
						F3_ADD:  ex.val = a + b;
						F3_SLL:  ex.val = a << b[4:0];
						F3_XOR:  ex.val = a ^ b;
						F3_SRL:  ex.val = a >> b[4:0];
						F3_OR:   ex.val = a | b;
						F3_AND:  ex.val = a & b;
						default: ex.fault = FAULT_ILLEGAL;
					endcase
				end else if (f7 == F7_ALT && f3 == F3_ADD) begin
					ex.val = a - b;
				end else begin
					ex.fault = FAULT_ILLEGAL;
				end
			end
			default: ex.fault = FAULT_ILLEGAL;
		endcase

		// a faulting instruction leaves all state alone
		if (ex.fault != FAULT_NONE) begin
			ex.wr     = 1'b0;
			ex.taken  = 1'b0;
			ex.npc    = pc;
			ex.load_b = 1'b0;
			ex.load_w = 1'b0;
			ex.store  = 1'b0;
		end
		if (rd == 5'd0) begin
			ex.wr = 1'b0;
		end
		if (!ex.wr) begin
			ex.rd     = '0;
			ex.val    = '0;
			ex.load_b = 1'b0;
			ex.load_w = 1'b0;
		end
	end

endmodule

FILE: hw/rtl/rv32i_subset_execute_step.sv
`timescale 1ns / 1ps
// rv32i subset execute step: register file and data memory in synchronous ram
// flow: an accepted instruction passes the execute state, then the memory state, then the
// output register; a new instruction enters only as the previous one leaves the memory
// state, since each needs the register file read, then data memory access and write-back
// in turn; reset: pc loads 0, registers read as zero, then a clearing sweep over all
// DATA_BYTES/4 words zeroes the data memory while no instruction is accepted
// depends on rvx_pkg, rvx_regfile, rvx_dmem, rvx_exec

module rv32i_subset_execute_step
	import rvx_pkg::*;
#(
	parameter int unsigned DATA_BYTES = DATA_BYTES_DEF,
	localparam int unsigned AW = $clog2(DATA_BYTES / 4)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instruction_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_pc,
	output logic        dest_written,
	output logic [4:0]  dest_index,
	output logic [31:0] dest_value,
	output logic        branch_taken,
	output logic [1:0]  fault
);

	state_t      state_q;
	state_t      state_nxt;
	logic [31:0] pc_q;
	logic [31:0] instr_s1;
	exec_t       ex_c;
	exec_t       ex_s2;
	logic        accept;
	logic        done;
	logic        clr_busy;

	// register file side
	logic [31:0] rf_a;
	logic [31:0] rf_b;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic        rf_we;
	logic [31:0] wb_val;
	logic        fwd_en_q;
	logic [4:0]  fwd_idx_q;
	logic [31:0] fwd_val_q;

	// data memory side
	logic        dm_en;
	logic [31:0] dm_rdata;
	logic [7:0]  ld_byte;

	// output register
	logic        out_valid_q;
	logic [31:0] next_pc_q;
	logic        dest_written_q;
	logic [4:0]  dest_index_q;
	logic [31:0] dest_value_q;
	logic        branch_taken_q;
	logic [1:0]  fault_q;

	// result leaves the memory stage once the output register is free
	assign done   = (state_q == ST_MEM) && (!out_valid_q || !out_stall);
	assign accept = in_valid && !in_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) begin
				state_nxt = ST_EX;
			end
			ST_EX: state_nxt = ST_MEM;
			ST_MEM: if (done) begin
				state_nxt = accept ? ST_EX : ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// handshake outputs: a new transaction may enter as the previous one retires
	always_comb begin
		unique case (state_q)
			ST_IDLE: in_stall = clr_busy;
			ST_EX:   in_stall = 1'b1;
			ST_MEM:  in_stall = !done;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// instruction register; operand reads issue on the same edge
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instruction_word;
		end
	end

	rvx_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.re      (accept),
		.ra      (instruction_word[19:15]),
		.rb      (instruction_word[24:20]),
		.rdata_a (rf_a),
		.rdata_b (rf_b),
		.we      (rf_we),
		.wa      (ex_s2.rd),
		.wd      (wb_val)
	);

	// write-back on the accept edge is missed by the ram read, so forward it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q <= 1'b0;
		end else begin
			fwd_en_q <= rf_we;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			fwd_idx_q <= ex_s2.rd;
			fwd_val_q <= wb_val;
		end
	end

	assign op_a = (fwd_en_q && fwd_idx_q == instr_s1[19:15]) ? fwd_val_q : rf_a;
	assign op_b = (fwd_en_q && fwd_idx_q == instr_s1[24:20]) ? fwd_val_q : rf_b;

	rvx_exec u_exec (
		.instr (instr_s1),
		.a     (op_a),
		.b     (op_b),
		.pc    (pc_q),
		.ex    (ex_c)
	);

	// pc moves at the end of execute; a config write reloads it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (cfg_we) begin
			pc_q <= cfg_wdata;
		end else if (state_q == ST_EX) begin
			pc_q <= ex_c.npc;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EX) begin
			ex_s2 <= ex_c;
		end
	end

	// stores write and loads read during execute
	assign dm_en = (state_q == ST_EX) && (ex_c.load_b || ex_c.load_w || ex_c.store);

	rvx_dmem #(
		.DATA_BYTES (DATA_BYTES)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (dm_en),
		.we     (ex_c.store),
		.be     (ex_c.be),
		.addr   (ex_c.addr[AW+1:2]),
		.wdata  (ex_c.wdata),
		.rdata  (dm_rdata),
		.busy   (clr_busy)
	);

	// little-endian byte pick and sign extension for byte loads
	always_comb begin
		unique case (ex_s2.addr[1:0])
			2'd0: ld_byte = dm_rdata[7:0];
			2'd1: ld_byte = dm_rdata[15:8];
			2'd2: ld_byte = dm_rdata[23:16];
			default: ld_byte = dm_rdata[31:24];
		endcase
		priority if (ex_s2.load_b) begin
			wb_val = {{24{ld_byte[7]}}, ld_byte};
		end else if (ex_s2.load_w) begin
			wb_val = dm_rdata;
		end else begin
			wb_val = ex_s2.val;
		end
	end

	assign rf_we = done && ex_s2.wr;

	// output register parts the pipeline from the result consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			next_pc_q      <= ex_s2.npc;
			dest_written_q <= ex_s2.wr;
			dest_index_q   <= ex_s2.rd;
			dest_value_q   <= wb_val;
			branch_taken_q <= ex_s2.taken;
			fault_q        <= ex_s2.fault;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_pc      = next_pc_q;
	assign dest_written = dest_written_q;
	assign dest_index   = dest_index_q;
	assign dest_value   = dest_value_q;
	assign branch_taken = branch_taken_q;
	assign fault        = fault_q;

endmodule

FILE: dv/rv32i_subset_execute_step_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for rv32i_subset_execute_step: directed then random
// instruction streams checked against an in-bench model of the architectural state
// depends on rvx_pkg and the rv32i_subset_execute_step rtl

module rv32i_subset_execute_step_tb;
	import rvx_pkg::*;

	localparam int unsigned MEM_BYTES = DATA_BYTES_DEF;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned SETTLE_CYCLES = 8;

	// one retired instruction as seen on the result port
	typedef struct {
		logic [31:0] npc;
		logic        wr;
		logic [4:0]  rd;
		logic [31:0] val;
		logic        taken;
		logic [1:0]  flt;
	} retire_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] instruction_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] next_pc;
	logic        dest_written;
	logic [4:0]  dest_index;
	logic [31:0] dest_value;
	logic        branch_taken;
	logic [1:0]  fault;

	rv32i_subset_execute_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.instruction_word(instruction_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.next_pc(next_pc),
		.dest_written(dest_written),
		.dest_index(dest_index),
		.dest_value(dest_value),
		.branch_taken(branch_taken),
		.fault(fault)
	);

	always #10 clk = ~clk;

	// architectural shadow state
	logic [31:0] arch_regs [32];
	logic [31:0] arch_pc;
	logic [7:0]  arch_mem [MEM_BYTES];

	logic [31:0] instr_q [$];      // instructions waiting to be offered
	retire_t     retire_q [$];     // expected retirements in program order
	int unsigned mismatches = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned hold_req = 0;     // bumped to request a long receiver hold-off
	int unsigned hold_seen = 0;
	int unsigned hold_len = 0;
	int unsigned hold_left = 0;
	int unsigned cycles = 0;

	// instruction encoders
	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OPC_OP};
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] opc);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
	endfunction

	function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] opc);
		return {imm, rd, opc};
	endfunction

	function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
	endfunction

	// executes one instruction on the shadow state and returns its retirement
	function automatic retire_t execute_instr(logic [31:0] w);
		logic [6:0]  opc;
		logic [4:0]  rd, rs1, rs2;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [31:0] a, b, pc, npc, val, addr;
		logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
		logic        wr, taken, st_b, st_w;
		logic [1:0]  flt;
		retire_t     r;
		opc = w[6:0];
		rd = w[11:7];
		f3 = w[14:12];
		rs1 = w[19:15];
		rs2 = w[24:20];
		f7 = w[31:25];
		a = arch_regs[rs1];
		b = arch_regs[rs2];
		pc = arch_pc;
		npc = pc + 32'd4;
		imm_i = {{20{w[31]}}, w[31:20]};
		imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
		imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
		imm_u = {w[31:12], 12'b0};
		wr = 1'b0;
		taken = 1'b0;
		st_b = 1'b0;
		st_w = 1'b0;
		val = '0;
		addr = '0;
		flt = FAULT_NONE;
		case (opc)
			OPC_LUI: begin
				wr = 1'b1; val = imm_u;
			end
			OPC_AUIPC: begin
				wr = 1'b1; val = pc + imm_u;
			end
			OPC_JAL: begin
				wr = 1'b1; val = pc + 32'd4; npc = pc + imm_j; taken = 1'b1;
			end
			OPC_JALR: begin
				if (f3 != F3_ADD) flt = FAULT_ILLEGAL;
				else begin
					// target from the old rs1, even when rd is the same register
					wr = 1'b1; val = pc + 32'd4; npc = (a + imm_i) & JALR_MASK;
					taken = 1'b1;
				end
			end
			OPC_BRANCH: begin
				case (f3)
					F3_BEQ:  taken = (a == b);
					F3_BNE:  taken = (a != b);
					F3_BLT:  taken = ($signed(a) < $signed(b));
					F3_BGE:  taken = ($signed(a) >= $signed(b));
					F3_BLTU: taken = (a < b);
					F3_BGEU: taken = (a >= b);
					default: flt = FAULT_ILLEGAL;
				endcase
				if (taken) npc = pc + imm_b;
			end
			OPC_LOAD: begin
				addr = a + imm_i;
				if (f3 == F3_B) begin
					wr = 1'b1;
					val = {{24{arch_mem[addr % MEM_BYTES][7]}}, arch_mem[addr % MEM_BYTES]};
				end else if (f3 == F3_W) begin
					if (addr[1:0] != 2'b00) flt = FAULT_MISALIGN;
					else begin
						wr = 1'b1;
						for (int i = 0; i < 4; i++)
							val[8*i +: 8] = arch_mem[(addr + i) % MEM_BYTES];
					end
				end else flt = FAULT_ILLEGAL;
			end
			OPC_STORE: begin
				addr = a + imm_s;
				if (f3 == F3_B) st_b = 1'b1;
				else if (f3 == F3_W) begin
					if (addr[1:0] != 2'b00) flt = FAULT_MISALIGN;
					else st_w = 1'b1;
				end else flt = FAULT_ILLEGAL;
			end
			OPC_OPIMM: begin
				wr = 1'b1;
				case (f3)
					F3_ADD:  val = a + imm_i;
					F3_XOR:  val = a ^ imm_i;
					F3_OR:   val = a | imm_i;
					F3_AND:  val = a & imm_i;
					default: flt = FAULT_ILLEGAL;
				endcase
			end
			OPC_OP: begin
				wr = 1'b1;
				if (f7 == F7_BASE) begin
					case (f3)
						F3_ADD:  val = a + b;
						F3_SLL:  val = a << b[4:0];
						F3_XOR:  val = a ^ b;
						F3_SRL:  val = a >> b[4:0];
						F3_OR:   val = a | b;
						F3_AND:  val = a & b;
						default: flt = FAULT_ILLEGAL;
					endcase
				end else if (f7 == F7_ALT && f3 == F3_ADD) val = a - b;
				else flt = FAULT_ILLEGAL;
			end
			default: flt = FAULT_ILLEGAL;
		endcase
		// a fault leaves all state untouched
		if (flt != FAULT_NONE) begin
			wr = 1'b0; taken = 1'b0; npc = pc; st_b = 1'b0; st_w = 1'b0;
		end
		if (st_b) arch_mem[addr % MEM_BYTES] = b[7:0];
		if (st_w)
			for (int i = 0; i < 4; i++)
				arch_mem[(addr + i) % MEM_BYTES] = b[8*i +: 8];
		if (rd == 5'd0) wr = 1'b0;
		if (!wr) begin
			val = '0; rd = '0;
		end else arch_regs[rd] = val;
		arch_pc = npc;
		r.npc = npc;
		r.wr = wr;
		r.rd = rd;
		r.val = val;
		r.taken = taken;
		r.flt = flt;
		return r;
	endfunction

	// mostly well-formed instructions with random fields, some raw noise
	function automatic logic [31:0] random_instr();
		logic [4:0]  rd, rs1, rs2;
		logic [11:0] imm;
		logic [2:0]  f3_br [6];
		logic [2:0]  f3_imm [4];
		logic [2:0]  f3_reg [6];
		f3_br = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU};
		f3_imm = '{F3_ADD, F3_XOR, F3_OR, F3_AND};
		f3_reg = '{F3_ADD, F3_SLL, F3_XOR, F3_SRL, F3_OR, F3_AND};
		rd = 5'($urandom);
		rs1 = 5'($urandom);
		rs2 = 5'($urandom);
		imm = 12'($urandom);
		if ($urandom_range(0, 99) < 8) return $urandom;
		// memory ops often go through x0 with a small offset so they hit the same bytes
		if ($urandom_range(0, 99) < 50) begin
			rs1 = 5'd0;
			imm = 12'($urandom_range(0, 63));
		end
		case ($urandom_range(0, 10))
			0: return enc_u(20'($urandom), rd, OPC_LUI);
			1: return enc_u(20'($urandom), rd, OPC_AUIPC);
			2: return enc_j(21'($urandom), rd);
			3: return enc_i(12'($urandom), rs1, F3_ADD, rd, OPC_JALR);
			4: return enc_b(13'($urandom), rs2, rs1, f3_br[$urandom_range(0, 5)]);
			5: return enc_i(imm, rs1, F3_B, rd, OPC_LOAD);
			6: return enc_i(imm, rs1, F3_W, rd, OPC_LOAD);
			7: return enc_s(imm, rs2, rs1, F3_B);
			8: return enc_s(imm, rs2, rs1, F3_W);
			9: return enc_i(12'($urandom), rs1, f3_imm[$urandom_range(0, 3)], rd, OPC_OPIMM);
			default: begin
				if ($urandom_range(0, 6) == 0) return enc_r(F7_ALT, rs2, rs1, F3_ADD, rd);
				return enc_r(F7_BASE, rs2, rs1, f3_reg[$urandom_range(0, 5)], rd);
			end
		endcase
	endfunction

	// driver: offers queued instructions, holds a stalled transaction steady
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) retire_q.push_back(execute_instr(instruction_word));
			if (!in_valid || !in_stall) begin
				if (instr_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					in_valid <= 1'b1;
					instruction_word <= instr_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each retirement in order and drives the receiver stall
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (retire_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction: next_pc %h", next_pc);
				end else begin
					retire_t e;
					e = retire_q.pop_front();
					if (next_pc !== e.npc || dest_written !== e.wr || dest_index !== e.rd ||
							dest_value !== e.val || branch_taken !== e.taken ||
							fault !== e.flt) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp pc %h wr %b rd %0d val %h tk %b flt %0d",
								e.npc, e.wr, e.rd, e.val, e.taken, e.flt);
							$display("          got pc %h wr %b rd %0d val %h tk %b flt %0d",
								next_pc, dest_written, dest_index, dest_value,
								branch_taken, fault);
						end
					end
				end
			end
			// long hold-off lets the block fill up and push back on its input
			if (hold_seen != hold_req) begin
				hold_seen <= hold_req;
				hold_left <= hold_len;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// waits until nothing is queued, offered or outstanding, then lets the pipe settle
	task automatic drain();
		do @(negedge clk);
		while (instr_q.size() != 0 || in_valid || retire_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reset_pc(logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		arch_pc = v;
	endtask

	task automatic queue_random(int unsigned n);
		repeat (n) instr_q.push_back(random_instr());
	endtask

	initial begin
		for (int i = 0; i < 32; i++) arch_regs[i] = '0;
		for (int i = 0; i < MEM_BYTES; i++) arch_mem[i] = '0;
		arch_pc = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles often, receiver idles most of the time
		tx_idle_pct = 34;
		rx_idle_pct = 85;
		write_reset_pc(32'h0000_0000);

		// directed: field extremes, every alu, load, store and jump operation, three of the branches and the corner cases
		instr_q.push_back(enc_u(20'hFFFFF, 5'd1, OPC_LUI));
		instr_q.push_back(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OPC_OPIMM));
		instr_q.push_back(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd3, OPC_OPIMM));
		instr_q.push_back(enc_i(12'd5, 5'd1, F3_ADD, 5'd0, OPC_OPIMM));      // write to x0
		instr_q.push_back(enc_u(20'h80000, 5'd4, OPC_AUIPC));
		instr_q.push_back(enc_r(F7_BASE, 5'd3, 5'd2, F3_ADD, 5'd5));
		instr_q.push_back(enc_r(F7_ALT, 5'd2, 5'd0, F3_ADD, 5'd6));
		instr_q.push_back(enc_r(F7_BASE, 5'd3, 5'd2, F3_SLL, 5'd7));        // shift by low 5 bits
		instr_q.push_back(enc_r(F7_BASE, 5'd2, 5'd2, F3_SRL, 5'd8));
		instr_q.push_back(enc_r(F7_BASE, 5'd3, 5'd1, F3_XOR, 5'd9));
		instr_q.push_back(enc_r(F7_BASE, 5'd3, 5'd1, F3_OR, 5'd10));
		instr_q.push_back(enc_r(F7_BASE, 5'd3, 5'd2, F3_AND, 5'd11));
		instr_q.push_back(enc_i(12'h800, 5'd2, F3_XOR, 5'd12, OPC_OPIMM));
		instr_q.push_back(enc_i(12'h0F0, 5'd3, F3_OR, 5'd13, OPC_OPIMM));
		instr_q.push_back(enc_i(12'h0F0, 5'd2, F3_AND, 5'd14, OPC_OPIMM));
		instr_q.push_back(enc_s(12'd0, 5'd2, 5'd0, F3_W));
		instr_q.push_back(enc_i(12'd0, 5'd0, F3_W, 5'd15, OPC_LOAD));
		instr_q.push_back(enc_s(12'd5, 5'd3, 5'd0, F3_B));
		instr_q.push_back(enc_i(12'd3, 5'd1, F3_B, 5'd16, OPC_LOAD));     // address wraps memory
		instr_q.push_back(enc_i(12'd1, 5'd0, F3_W, 5'd17, OPC_LOAD));     // misaligned load
		instr_q.push_back(enc_s(12'd2, 5'd2, 5'd0, F3_W));                // misaligned store
		instr_q.push_back(enc_i(12'd1, 5'd3, F3_ADD, 5'd3, OPC_JALR));    // rd same as rs1
		instr_q.push_back(enc_i(12'd0, 5'd3, F3_SLL, 5'd18, OPC_JALR));   // bad jalr funct3
		instr_q.push_back(enc_j(21'h100000, 5'd19));
		instr_q.push_back(enc_b(13'h1FFE, 5'd3, 5'd2, F3_BLT));
		instr_q.push_back(enc_b(13'h0FFE, 5'd3, 5'd2, F3_BLTU));
		instr_q.push_back(enc_b(13'd8, 5'd2, 5'd2, F3_BEQ));
		instr_q.push_back(32'hFFFF_FFFF);
		instr_q.push_back(32'h0000_0000);
		drain();

		// random with a long receiver hold-off while the sender keeps offering
		write_reset_pc(32'hFFFF_FFFC);
		queue_random(330);
		hold_len = 300;
		hold_req++;
		drain();

		// roles of the two sides swapped, pc at its top value
		tx_idle_pct = 85;
		rx_idle_pct = 34;
		write_reset_pc(32'hFFFF_FFFF);
		queue_random(330);
		drain();

		// full rate on both sides
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reset_pc(32'h0000_1000);
		queue_random(340);
		drain();

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
